/* design/assert_macros.svh */
// Assertion macros for the port-level checker of the waveshaper block.
// Depends on a clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AWD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("waveshaper assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AWD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("waveshaper assertion failed");

`endif

/* design/awd_pkg.sv */
// Package for the waveshaper distortion block: widths, register indexes,
// shaper codes, configuration struct and an elaboration-time divider.
// No dependencies.
package awd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS = SAMPLE_BITS - 1;
    localparam int CURVE_TABLE_DEPTH_DEF = 256;
    // drive product (Q.15 * Q8.8 = Q.23) to Q.30
    localparam int X_SHIFT = 30 - FRAC_BITS - 8;

    localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
    localparam logic [31:0] TWO_THIRDS_Q30 = 32'd715827883;
    localparam logic [63:0] TWO_OVER_PI_Q30 = 64'd683565276;
    localparam int TANH_RLOG2 = 3;
    localparam int ATAN_RLOG2 = 5;

    localparam logic [1:0] REG_SHAPER_MODE = 2'd0;
    localparam logic [1:0] REG_DRIVE_GAIN = 2'd1;
    localparam logic [1:0] REG_OUTPUT_GAIN = 2'd2;
    localparam logic [1:0] REG_WET_MIX = 2'd3;

    localparam logic [2:0] MODE_SOFT = 3'd0;
    localparam logic [2:0] MODE_HARD = 3'd1;
    localparam logic [2:0] MODE_TANH = 3'd2;
    localparam logic [2:0] MODE_ATAN = 3'd3;
    localparam logic [2:0] MODE_FOLD = 3'd4;

    localparam logic [2:0] MODE_RST = MODE_SOFT;
    localparam logic [15:0] DRIVE_RST = 16'd256;
    localparam logic [15:0] OGAIN_RST = 16'd16384;
    localparam logic [16:0] MIX_RST = 17'h10000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] drive;
        logic [15:0] out_gain;
        logic [16:0] mix;
    } awd_cfg_t;

    // Restoring divider, used only to build constant tables.
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d})
            begin
                rem = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

/* design/awd_drive.sv */
// Drive stage: sign/magnitude split and drive gain multiply.
// Depends on awd_pkg.
module awd_drive (
    input  logic                                  clk,
    input  logic                                  en,
    input  awd_pkg::awd_cfg_t                     cfg,
    input  logic signed [awd_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [awd_pkg::SAMPLE_BITS-1:0] dry,
    output logic                                  neg,
    output logic [31:0]                           full
);
    logic [15:0] mag;
    logic [15:0] drv;
    logic [31:0] full_next;
    logic signed [15:0] dry_reg;
    logic neg_reg;
    logic [31:0] full_reg;

    always_comb
    begin
        mag = sample[15] ? 16'(-sample) : 16'(sample);
        // drive never below unity
        drv = (cfg.drive < awd_pkg::DRIVE_RST) ? awd_pkg::DRIVE_RST : cfg.drive;
        full_next = {16'd0, mag} * {16'd0, drv};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dry_reg <= sample;
            neg_reg <= sample[15];
            full_reg <= full_next;
        end
    end

    assign dry = dry_reg;
    assign neg = neg_reg;
    assign full = full_reg;
endmodule

/* design/awd_shaper.sv */
// Shaper stages: cubic, hard clip, foldback and interpolated tanh/atan tables.
// Four register stages; tables are built at elaboration. Depends on awd_pkg.
module awd_shaper #(
    parameter int CURVE_TABLE_DEPTH = awd_pkg::CURVE_TABLE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  awd_pkg::awd_cfg_t                     cfg,
    input  logic [31:0]                           full,
    input  logic                                  neg_in,
    input  logic signed [awd_pkg::SAMPLE_BITS-1:0] dry_in,
    output logic signed [16:0]                    wet,
    output logic signed [awd_pkg::SAMPLE_BITS-1:0] dry_out
);
    localparam int D = CURVE_TABLE_DEPTH;
    localparam int IW = $clog2(D + 1);
    localparam int XW = 32 + awd_pkg::X_SHIFT;
    localparam int PW = XW + IW;
    localparam int T_LO = 14 + awd_pkg::TANH_RLOG2;
    localparam int A_LO = 14 + awd_pkg::ATAN_RLOG2;

    typedef logic [30:0] curve_t [0:D];

    function automatic curve_t build_tanh();
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] t;
        logic [63:0] acc;
        logic [63:0] cur;
        curve_t r;
        a = awd_pkg::udiv(64'd2 << (30 + awd_pkg::TANH_RLOG2), 64'(D));
        e = awd_pkg::ONE_Q30;
        t = awd_pkg::ONE_Q30;
        for (int n = 1; n <= 10; n++)
        begin
            t = awd_pkg::udiv((t * a) >> 30, 64'(n));
            e = ((n & 1) == 1) ? e - t : e + t;
        end
        acc = '0;
        for (int k = 0; k <= D; k++)
        begin
            cur = (k == 0) ? awd_pkg::ONE_Q30 : acc;
            r[k] = 31'(awd_pkg::udiv(((awd_pkg::ONE_Q30 - cur) << 30)
                                     + ((awd_pkg::ONE_Q30 + cur) >> 1),
                                     awd_pkg::ONE_Q30 + cur));
            acc = (cur * e + (awd_pkg::ONE_Q30 >> 1)) >> 30;
        end
        return r;
    endfunction

    function automatic curve_t build_atan();
        logic [63:0] acc;
        logic [63:0] den;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] u3;
        logic [63:0] u5;
        logic [63:0] dd;
        curve_t r;
        dd = 64'(D);
        acc = '0;
        r[0] = '0;
        for (int j = 1; j <= (D << awd_pkg::ATAN_RLOG2); j++)
        begin
            den = dd * dd + 64'(j - 1) * 64'(j);
            u = awd_pkg::udiv(awd_pkg::ONE_Q30 * dd + (den >> 1), den);
            u2 = (u * u + (awd_pkg::ONE_Q30 >> 1)) >> 30;
            u3 = (u2 * u + (awd_pkg::ONE_Q30 >> 1)) >> 30;
            u5 = (u3 * u2 + (awd_pkg::ONE_Q30 >> 1)) >> 30;
            acc = acc + u - awd_pkg::udiv(u3 + 64'd1, 64'd3)
                  + awd_pkg::udiv(u5 + 64'd2, 64'd5);
            if ((j & ((1 << awd_pkg::ATAN_RLOG2) - 1)) == 0)
            begin
                r[j >> awd_pkg::ATAN_RLOG2] = 31'((acc * awd_pkg::TWO_OVER_PI_Q30
                                                   + (awd_pkg::ONE_Q30 >> 1)) >> 30);
            end
        end
        return r;
    endfunction

    localparam curve_t TANH_TAB = build_tanh();
    localparam curve_t ATAN_TAB = build_atan();

    // stage B signals
    logic [XW-1:0] x;
    logic [PW-1:0] xd;
    logic [61:0] sq;
    logic [31:0] u;
    logic big;
    logic [30:0] xs;
    logic [30:0] x2_next;
    logic [30:0] hard_next;
    logic signed [31:0] fold_next;
    logic sat;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx1;
    logic [15:0] frac;
    logic [30:0] t0_next;
    logic [30:0] t1_next;
    logic [15:0] frac_next;

    logic [30:0] b_xs_reg;
    logic b_big_reg;
    logic [30:0] b_x2_reg;
    logic [30:0] b_hard_reg;
    logic signed [31:0] b_fold_reg;
    logic [30:0] b_t0_reg;
    logic [30:0] b_t1_reg;
    logic [15:0] b_frac_reg;
    logic b_neg_reg;
    logic signed [15:0] b_dry_reg;

    always_comb
    begin
        x = {full, awd_pkg::X_SHIFT'(0)};
        big = x > XW'(awd_pkg::ONE_Q30);
        xs = x[30:0];
        sq = {31'd0, xs} * {31'd0, xs};
        x2_next = 31'((sq + 62'(awd_pkg::ONE_Q30 >> 1)) >> 30);
        hard_next = big ? 31'(awd_pkg::ONE_Q30) : xs;
        u = x[31:0] + 32'(awd_pkg::ONE_Q30);
        fold_next = (u <= 32'h8000_0000) ? $signed(u - 32'h4000_0000)
                                         : $signed(32'hC000_0000 - u);
        xd = PW'(x) * PW'(D);
        if (cfg.mode == awd_pkg::MODE_ATAN)
        begin
            sat = |x[XW-1:30 + awd_pkg::ATAN_RLOG2];
            idx = xd[A_LO + 16 +: IW];
            frac = xd[A_LO +: 16];
        end
        else
        begin
            sat = |x[XW-1:30 + awd_pkg::TANH_RLOG2];
            idx = xd[T_LO + 16 +: IW];
            frac = xd[T_LO +: 16];
        end
        // beyond the table: hold the last entry
        if (sat)
        begin
            idx = IW'(D);
            frac = '0;
        end
        idx1 = sat ? idx : idx + IW'(1);
        t0_next = (cfg.mode == awd_pkg::MODE_ATAN) ? ATAN_TAB[idx] : TANH_TAB[idx];
        t1_next = (cfg.mode == awd_pkg::MODE_ATAN) ? ATAN_TAB[idx1] : TANH_TAB[idx1];
        frac_next = frac;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_xs_reg <= xs;
            b_big_reg <= big;
            b_x2_reg <= x2_next;
            b_hard_reg <= hard_next;
            b_fold_reg <= fold_next;
            b_t0_reg <= t0_next;
            b_t1_reg <= t1_next;
            b_frac_reg <= frac_next;
            b_neg_reg <= neg_in;
            b_dry_reg <= dry_in;
        end
    end

    // stage C: cube and interpolation products
    logic [61:0] cu;
    logic [30:0] x3_next;
    logic [47:0] p0_next;
    logic [47:0] p1_next;

    logic [30:0] c_x3_reg;
    logic [47:0] c_p0_reg;
    logic [47:0] c_p1_reg;
    logic [30:0] c_xs_reg;
    logic c_big_reg;
    logic [30:0] c_hard_reg;
    logic signed [31:0] c_fold_reg;
    logic c_neg_reg;
    logic signed [15:0] c_dry_reg;

    always_comb
    begin
        cu = {31'd0, b_x2_reg} * {31'd0, b_xs_reg};
        x3_next = 31'((cu + 62'(awd_pkg::ONE_Q30 >> 1)) >> 30);
        p0_next = {17'd0, b_t0_reg} * 48'(17'h10000 - {1'b0, b_frac_reg});
        p1_next = {17'd0, b_t1_reg} * {32'd0, b_frac_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_x3_reg <= x3_next;
            c_p0_reg <= p0_next;
            c_p1_reg <= p1_next;
            c_xs_reg <= b_xs_reg;
            c_big_reg <= b_big_reg;
            c_hard_reg <= b_hard_reg;
            c_fold_reg <= b_fold_reg;
            c_neg_reg <= b_neg_reg;
            c_dry_reg <= b_dry_reg;
        end
    end

    // stage D: divide by three via reciprocal, finish interpolation, select
    logic [63:0] q3p;
    logic [30:0] q3;
    logic signed [31:0] soft_val;
    logic [48:0] isum;
    logic [30:0] interp;
    logic signed [31:0] shape_next;

    logic signed [31:0] d_shape_reg;
    logic d_neg_reg;
    logic signed [15:0] d_dry_reg;

    always_comb
    begin
        q3p = {32'd0, 32'(c_x3_reg) + 32'd1} * 64'h0000_0000_AAAA_AAAB;
        q3 = q3p[63:33];
        soft_val = c_big_reg ? $signed(awd_pkg::TWO_THIRDS_Q30)
                             : $signed(32'(c_xs_reg) - 32'(q3));
        isum = 49'(c_p0_reg) + 49'(c_p1_reg) + 49'd32768;
        interp = isum[46:16];
        case (cfg.mode)
            awd_pkg::MODE_SOFT: shape_next = soft_val;
            awd_pkg::MODE_HARD: shape_next = $signed({1'b0, c_hard_reg});
            awd_pkg::MODE_FOLD: shape_next = c_fold_reg;
            default:            shape_next = $signed({1'b0, interp});
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_shape_reg <= shape_next;
            d_neg_reg <= c_neg_reg;
            d_dry_reg <= c_dry_reg;
        end
    end

    // stage E: apply input sign, round half away from zero to Q.15
    logic [31:0] smag;
    logic [31:0] rsum;
    logic [15:0] rmag;
    logic signed [16:0] wet_next;
    logic signed [16:0] e_wet_reg;
    logic signed [15:0] e_dry_reg;

    always_comb
    begin
        smag = d_shape_reg[31] ? 32'(-d_shape_reg) : 32'(d_shape_reg);
        rsum = smag + 32'h0000_4000;
        rmag = rsum[30:15];
        wet_next = (d_shape_reg[31] ^ d_neg_reg) ? -$signed({1'b0, rmag})
                                                 : $signed({1'b0, rmag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_wet_reg <= wet_next;
            e_dry_reg <= d_dry_reg;
        end
    end

    assign wet = e_wet_reg;
    assign dry_out = e_dry_reg;
endmodule

/* design/awd_mix.sv */
// Mix stages: dry/wet crossfade, output gain, rounding and saturation.
// Three register stages, the last is the output register. Depends on awd_pkg.
module awd_mix (
    input  logic                                  clk,
    input  logic                                  en,
    input  awd_pkg::awd_cfg_t                     cfg,
    input  logic signed [awd_pkg::SAMPLE_BITS-1:0] dry,
    input  logic signed [16:0]                    wet,
    output logic signed [awd_pkg::SAMPLE_BITS-1:0] sample_out
);
    logic [16:0] mixc;
    logic [16:0] dw;
    logic signed [33:0] acc_next;
    logic signed [33:0] f_acc_reg;
    logic signed [50:0] prod_next;
    logic signed [50:0] g_prod_reg;
    logic [50:0] pm;
    logic [50:0] psum;
    logic [19:0] r;
    logic [15:0] res_next;
    logic signed [15:0] h_res_reg;

    always_comb
    begin
        mixc = (cfg.mix > 17'h10000) ? 17'h10000 : cfg.mix;
        dw = 17'h10000 - mixc;
        acc_next = 34'(dry) * 34'($signed({1'b0, dw}))
                 + 34'(wet) * 34'($signed({1'b0, mixc}));
        prod_next = 51'(f_acc_reg) * 51'($signed({1'b0, cfg.out_gain}));
        pm = g_prod_reg[50] ? 51'(-g_prod_reg) : 51'(g_prod_reg);
        psum = pm + 51'h4000_0000;
        r = psum[50:31];
        if (g_prod_reg[50])
        begin
            res_next = (r > 20'h08000) ? 16'h8000 : 16'(-r);
        end
        else
        begin
            res_next = (r > 20'h07FFF) ? 16'h7FFF : r[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_acc_reg <= acc_next;
            g_prod_reg <= prod_next;
            h_res_reg <= $signed(res_next);
        end
    end

    assign sample_out = h_res_reg;
endmodule

/* design/audio_waveshaper_distortion_top.sv */
// Waveshaping distortion for a stream of signed Q1.15 audio samples. Each sample
// is scaled by the drive gain, shaped by the curve chosen in shaper_mode (cubic
// soft clip, hard clip, tanh, (2/pi)atan or triangle foldback; codes 5 to 7 act
// as tanh), crossfaded with the dry sample by wet_mix, scaled by output_gain,
// rounded and saturated. The block is an eight-stage pipeline: one sample enters
// per cycle while it is not held, and the whole pipeline holds only while the
// output register carries a result that is not taken. tlast rides along with its
// sample. Write configuration only while no sample is in flight. Depends on
// awd_pkg, awd_drive, awd_shaper and awd_mix.
module audio_waveshaper_distortion_top #(
    parameter int CURVE_TABLE_DEPTH = awd_pkg::CURVE_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_in
    input  logic        s_tlast,   // block_end_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    output logic        m_tlast,   // block_end_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata
);
    localparam int STAGES = 8;

    logic [2:0]  mode_reg;
    logic [15:0] drive_reg;
    logic [15:0] ogain_reg;
    logic [16:0] mix_reg;
    awd_pkg::awd_cfg_t cfg;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] last_reg;
    logic [STAGES-1:0] last_next;
    logic en;

    logic signed [15:0] a_dry;
    logic a_neg;
    logic [31:0] a_full;
    logic signed [16:0] e_wet;
    logic signed [15:0] e_dry;
    logic signed [15:0] h_sample;

    // Register file: plain writes, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= awd_pkg::MODE_RST;
            drive_reg <= awd_pkg::DRIVE_RST;
            ogain_reg <= awd_pkg::OGAIN_RST;
            mix_reg <= awd_pkg::MIX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                awd_pkg::REG_SHAPER_MODE: mode_reg <= cfg_wdata[2:0];
                awd_pkg::REG_DRIVE_GAIN:  drive_reg <= cfg_wdata[15:0];
                awd_pkg::REG_OUTPUT_GAIN: ogain_reg <= cfg_wdata[15:0];
                awd_pkg::REG_WET_MIX:     mix_reg <= cfg_wdata;
                default:                  mix_reg <= mix_reg;
            endcase
        end
    end

    assign cfg = '{mode: mode_reg, drive: drive_reg, out_gain: ogain_reg, mix: mix_reg};

    // Advance every stage unless the output register holds an untaken result.
    assign en = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], s_tvalid};
        last_next = {last_reg[STAGES-2:0], s_tlast};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg <= last_next;
        end
    end

    awd_drive u_drive (
        .clk    (clk),
        .en     (en),
        .cfg    (cfg),
        .sample ($signed(s_tdata)),
        .dry    (a_dry),
        .neg    (a_neg),
        .full   (a_full)
    );

    awd_shaper #(
        .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH)
    ) u_shaper (
        .clk     (clk),
        .en      (en),
        .cfg     (cfg),
        .full    (a_full),
        .neg_in  (a_neg),
        .dry_in  (a_dry),
        .wet     (e_wet),
        .dry_out (e_dry)
    );

    awd_mix u_mix (
        .clk        (clk),
        .en         (en),
        .cfg        (cfg),
        .dry        (e_dry),
        .wet        (e_wet),
        .sample_out (h_sample)
    );

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata = h_sample;
    assign m_tlast = last_reg[STAGES-1];
endmodule

/* design/awd_checker.sv */
// Port-level checker for the waveshaper top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module awd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    // a stalled result holds
    `AWD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    // input side open whenever the output side can drain
    `AWD_ASSERT_IMPL(a_ready_open, !m_tvalid || m_tready, s_tready)
    // input side closed while the output stalls
    `AWD_ASSERT_IMPL(a_ready_shut, m_tvalid && !m_tready, !s_tready)
endmodule

bind audio_waveshaper_distortion_top awd_checker u_awd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* dv/tb.sv */
// Self-checking testbench for audio_waveshaper_distortion_top: directed and random
// samples over every shaper mode and gain/mix extremes, checked against a local predictor.
// Depends on awd_pkg and the RTL of the waveshaper block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam int DEPTH = awd_pkg::CURVE_TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;

    // Predicts the shaped sample for each accepted transaction and holds the
    // expected results in arrival order.
    class shaper_scoreboard;
        logic [31:0] tanh_tab [DEPTH + 1];
        logic [31:0] atan_tab [DEPTH + 1];
        logic [2:0]  mode;
        logic [15:0] drive;
        logic [15:0] out_gain;
        logic [16:0] mix;
        logic [16:0] expected_samples [$];
        int errors;
        int results;

        function new();
            longint unsigned a, e, t, ek, den, u, u2, u3, u5, acc;
            mode = awd_pkg::MODE_RST;
            drive = awd_pkg::DRIVE_RST;
            out_gain = awd_pkg::OGAIN_RST;
            mix = awd_pkg::MIX_RST;
            errors = 0;
            results = 0;
            // exp(-16/DEPTH) by Taylor series
            a = (64'd2 << (30 + awd_pkg::TANH_RLOG2)) / DEPTH;
            e = Q30;
            t = Q30;
            for (int n = 1; n <= 10; n++)
            begin
                t = ((t * a) >> 30) / n;
                e = (n % 2 == 1) ? e - t : e + t;
            end
            ek = Q30;
            for (int k = 0; k <= DEPTH; k++)
            begin
                tanh_tab[k] = 32'((((Q30 - ek) << 30) + (Q30 + ek) / 2) / (Q30 + ek));
                ek = (ek * e + (Q30 >> 1)) >> 30;
            end
            // atan by summing atan of the angle increments
            acc = 0;
            atan_tab[0] = 0;
            for (longint unsigned j = 1; j <= DEPTH * 32; j++)
            begin
                den = DEPTH * DEPTH + (j - 1) * j;
                u = (Q30 * DEPTH + den / 2) / den;
                u2 = (u * u + (Q30 >> 1)) >> 30;
                u3 = (u2 * u + (Q30 >> 1)) >> 30;
                u5 = (u3 * u2 + (Q30 >> 1)) >> 30;
                acc += u - (u3 + 1) / 3 + (u5 + 2) / 5;
                if (j % 32 == 0)
                    atan_tab[j / 32] = 32'((acc * awd_pkg::TWO_OVER_PI_Q30 + (Q30 >> 1)) >> 30);
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                awd_pkg::REG_SHAPER_MODE: mode = val[2:0];
                awd_pkg::REG_DRIVE_GAIN:  drive = val[15:0];
                awd_pkg::REG_OUTPUT_GAIN: out_gain = val[15:0];
                default:                  mix = val;
            endcase
        endfunction

        function longint curve_lookup(bit use_atan, longint unsigned x);
            longint unsigned pos, idx, frac, sum;
            int rlog2;
            rlog2 = use_atan ? awd_pkg::ATAN_RLOG2 : awd_pkg::TANH_RLOG2;
            if (x >= (Q30 << rlog2))
                return use_atan ? atan_tab[DEPTH] : tanh_tab[DEPTH];
            pos = (x * DEPTH) >> (14 + rlog2);
            idx = pos >> 16;
            frac = pos & 64'hFFFF;
            if (idx >= DEPTH)
                return use_atan ? atan_tab[DEPTH] : tanh_tab[DEPTH];
            if (use_atan)
                sum = atan_tab[idx] * (65536 - frac) + atan_tab[idx + 1] * frac;
            else
                sum = tanh_tab[idx] * (65536 - frac) + tanh_tab[idx + 1] * frac;
            return longint'((sum + 32768) >> 16);
        endfunction

        function longint shape_curve(longint unsigned x);
            longint unsigned u, x2, x3;
            case (mode)
                awd_pkg::MODE_SOFT:
                begin
                    if (x > Q30)
                        return longint'(awd_pkg::TWO_THIRDS_Q30);
                    x2 = (x * x + (Q30 >> 1)) >> 30;
                    x3 = (x2 * x + (Q30 >> 1)) >> 30;
                    return longint'(x) - longint'((x3 + 1) / 3);
                end
                awd_pkg::MODE_HARD: return longint'(x > Q30 ? Q30 : x);
                awd_pkg::MODE_ATAN: return curve_lookup(1'b1, x);
                awd_pkg::MODE_FOLD:
                begin
                    u = (x + Q30) & 64'hFFFF_FFFF;
                    if (u <= (Q30 << 1))
                        return longint'(u) - longint'(Q30);
                    return longint'(3 * Q30) - longint'(u);
                end
                default: return curve_lookup(1'b0, x);
            endcase
        endfunction

        // Note an accepted input sample and queue its expected result.
        function void note_sample(logic [15:0] sample, logic last);
            longint dry, wet, acc, prod, mixl;
            longint unsigned mag, x, wmag, pm, r, drv;
            logic [15:0] res;
            dry = longint'($signed(sample));
            mag = longint'(dry < 0 ? -dry : dry);
            drv = (drive < 256) ? 256 : drive;
            x = (mag * drv) << awd_pkg::X_SHIFT;
            wet = shape_curve(x);
            if (dry < 0)
                wet = -wet;
            wmag = longint'(wet < 0 ? -wet : wet);
            wmag = (wmag + (64'd1 << 14)) >> 15;
            wet = (wet < 0) ? -longint'(wmag) : longint'(wmag);
            mixl = (mix > 65536) ? 65536 : longint'(mix);
            acc = dry * (65536 - mixl) + wet * mixl;
            prod = acc * longint'(out_gain);
            pm = longint'(prod < 0 ? -prod : prod);
            r = (pm + (64'd1 << 30)) >> 31;
            if (prod < 0)
            begin
                if (r > 32768)
                    r = 32768;
                res = 16'(-longint'(r));
            end
            else
            begin
                if (r > 32767)
                    r = 32767;
                res = 16'(r);
            end
            expected_samples.push_back({last, res});
        endfunction

        // Check one output transaction against the oldest expectation.
        function void check_result(logic [15:0] sample, logic last);
            logic [16:0] exp_item;
            results++;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected result sample=%0d last=%0b", $time,
                         $signed(sample), last);
                errors++;
                return;
            end
            exp_item = expected_samples.pop_front();
            if (exp_item[15:0] !== sample)
            begin
                $display("%0t: sample mismatch expected=%0d actual=%0d", $time,
                         $signed(exp_item[15:0]), $signed(sample));
                errors++;
            end
            if (exp_item[16] !== last)
            begin
                $display("%0t: tlast mismatch expected=%0b actual=%0b", $time,
                         exp_item[16], last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_wdata;

    shaper_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int idle_count;
    int samples_sent;

    audio_waveshaper_distortion_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Receiver: check at the rising edge, then decide tready for the next cycle.
    // A pending hold-off overrides the random stall.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one sample, with random idle cycles first; hold until accepted.
    task automatic send_sample(logic [15:0] sample, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= sample;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(sample, last);
        samples_sent++;
        @(negedge clk);
    endtask

    // Drain every expected result, then let the pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Mostly full-scale random, with small values and extremes mixed in.
    function automatic logic [15:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return 16'($urandom);
        if (pick < 8)
            return 16'($signed(17'($urandom_range(2048)) - 17'sd1024));
        case ($urandom_range(3))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial
    begin
        logic [15:0] directed [$];
        logic [15:0] drv_val;
        logic [15:0] gain_val;
        logic [16:0] mix_val;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = awd_pkg::REG_SHAPER_MODE;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_count = 0;
        samples_sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: field extremes and soft-clip knee with reset settings.
        directed = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h4000,
                     16'hC000, 16'h5555, 16'hAAAB, 16'h2000, 16'hE000, 16'h7FFE,
                     16'h8001, 16'h00FF, 16'hFF01, 16'h3FFF, 16'hC001, 16'h1234};
        foreach (directed[i])
            send_sample(directed[i], i[0]);
        wait_drained();

        // Sixteen settings: every mode twice, drive/gain/mix extremes early.
        for (int phase = 0; phase < 16; phase++)
        begin
            case (phase % 5)
                0: drv_val = 16'd0;
                1: drv_val = 16'd256;
                2: drv_val = 16'hFFFF;
                3: drv_val = 16'd255;
                default: drv_val = 16'($urandom_range(256, 4096));
            endcase
            case (phase % 4)
                0: gain_val = 16'hFFFF;
                1: gain_val = 16'd0;
                2: gain_val = 16'd32768;
                default: gain_val = 16'($urandom);
            endcase
            case (phase % 6)
                0: mix_val = 17'h10000;
                1: mix_val = 17'd0;
                2: mix_val = 17'h1FFFF;
                3: mix_val = 17'($urandom_range(65537, 131071));
                default: mix_val = 17'($urandom_range(65536));
            endcase
            write_reg(awd_pkg::REG_SHAPER_MODE, 17'(phase % 8));
            write_reg(awd_pkg::REG_DRIVE_GAIN, {1'b0, drv_val});
            write_reg(awd_pkg::REG_OUTPUT_GAIN, {1'b0, gain_val});
            write_reg(awd_pkg::REG_WET_MIX, mix_val);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // Back up the pipeline once: receiver blocked while samples keep coming.
            if (phase == 4)
                hold_off_cycles = 200;
            for (int n = 0; n < 114; n++)
                send_sample(random_sample(), 1'($urandom_range(1)));
            wait_drained();
        end

        $display("Covered %0d samples over all eight shaper modes with drive, output gain",
                 samples_sent);
        $display("and wet mix at their extremes; %0d results checked.", sb.results);
        if (sb.errors == 0 && sb.expected_samples.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* audio_waveshaper_distortion_top.f */
+incdir+design
design/awd_pkg.sv
design/awd_drive.sv
design/awd_shaper.sv
design/awd_mix.sv
design/audio_waveshaper_distortion_top.sv
design/awd_checker.sv
dv/tb.sv
